// File: hw/rtl/smo_pu_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// smo_pu_pkg
// Shared codes and the word record carried down the SMO pair update pipe.
// ---------------------------------------------------------------------------
package smo_pu_pkg;

    localparam int ADDR_W = 3;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_SMALL = 2'd2;

    // how the second multiplier is picked
    localparam logic [1:0] CH_NEWTON = 2'd0;
    localparam logic [1:0] CH_LO     = 2'd1;
    localparam logic [1:0] CH_HI     = 2'd2;
    localparam logic [1:0] CH_KEEP   = 2'd3;

    // register index (paddr[2])
    localparam logic REG_BOX_C    = 1'b0;
    localparam logic REG_STEP_TOL = 1'b1;

    localparam logic [30:0] BOX_C_RST    = 31'd65536;
    localparam logic [15:0] STEP_TOL_RST = 16'd66;

    typedef struct packed {
        logic               y1;
        logic               y2;
        logic [30:0]        a1;
        logic [30:0]        a2;
        logic signed [31:0] e1;
        logic signed [31:0] e2;
        logic signed [31:0] k11;
        logic signed [31:0] kc;
        logic signed [31:0] k22;
        logic signed [31:0] bias;
        logic [1:0]         status;
        logic [30:0]        lo;
        logic [30:0]        hi;
        logic signed [34:0] eta;
        logic [32:0]        nmag;
        logic               qneg;
        logic [1:0]         choice;
        logic [30:0]        n1;
        logic [30:0]        n2;
    } t_item;

endpackage
`default_nettype wire

// File: hw/rtl/smo_pu_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// smo_pu_div
// Pipelined restoring unsigned divider, one quotient bit per stage.
// ---------------------------------------------------------------------------
module smo_pu_div #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 35
) (
    input  wire              i_clk,
    input  wire              i_en,
    input  wire [NUM_W-1:0]  i_num,
    input  wire [DEN_W-1:0]  i_den,
    output logic [NUM_W-1:0] o_quo
);

    logic [DEN_W-1:0] r_rem [NUM_W];
    logic [NUM_W-1:0] r_quo [NUM_W];
    logic [NUM_W-1:0] r_num [NUM_W];
    logic [DEN_W-1:0] r_den [NUM_W];

    logic [DEN_W-1:0] n_rem [NUM_W];
    logic [NUM_W-1:0] n_quo [NUM_W];
    logic [NUM_W-1:0] n_num [NUM_W];
    logic [DEN_W-1:0] n_den [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_step
        logic [DEN_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [NUM_W-1:0] w_quo_in;
        logic [NUM_W-1:0] w_num_in;
        logic [DEN_W:0]   w_trial;
        logic             w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_quo_in = '0;
            assign w_num_in = i_num;
            assign w_den_in = i_den;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
            assign w_num_in = r_num[k-1];
            assign w_den_in = r_den[k-1];
        end

        assign w_trial  = {w_rem_in, w_num_in[NUM_W-1]};
        assign w_ge     = w_trial >= {1'b0, w_den_in};
        assign n_rem[k] = w_ge ? DEN_W'(w_trial - {1'b0, w_den_in}) : w_trial[DEN_W-1:0];
        assign n_quo[k] = {w_quo_in[NUM_W-2:0], w_ge};
        assign n_num[k] = {w_num_in[NUM_W-2:0], 1'b0};
        assign n_den[k] = w_den_in;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NUM_W; j++) begin
                r_rem[j] <= n_rem[j];
                r_quo[j] <= n_quo[j];
                r_num[j] <= n_num[j];
                r_den[j] <= n_den[j];
            end
        end
    end

    assign o_quo = r_quo[NUM_W-1];

endmodule
`default_nettype wire

// File: hw/rtl/svm_smo_pair_update.sv
`default_nettype none
// ---------------------------------------------------------------------------
// svm_smo_pair_update
// SMO analytic two-multiplier step: bounds, eta, Newton step or endpoint
// choice, first multiplier clip and bias recompute, in Q(31-F).F.
// ---------------------------------------------------------------------------
// Depth: the restoring divider of the Newton step, one quotient bit per stage,
// makes up most of the pipe.
// Throughput: one word per cycle; the whole pipe holds while the output
// register waits on i_ready.
// Reset (synchronous, active low): stage valid bits clear, box_c = 1.0 and
// step_tolerance = 66.
module svm_smo_pair_update
    import smo_pu_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [ADDR_W-1:0]  paddr,
    input  wire [31:0]        pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire               i_valid,
    output logic              o_ready,
    input  wire               i_first_label,
    input  wire               i_second_label,
    input  wire [30:0]        i_first_alpha,
    input  wire [30:0]        i_second_alpha,
    input  wire signed [31:0] i_first_error,
    input  wire signed [31:0] i_second_error,
    input  wire signed [31:0] i_kernel_first_first,
    input  wire signed [31:0] i_kernel_cross,
    input  wire signed [31:0] i_kernel_second_second,
    input  wire signed [31:0] i_bias_in,
    output logic              o_valid,
    input  wire               i_ready,
    output logic [1:0]        o_status,
    output logic [30:0]       o_new_first_alpha,
    output logic [30:0]       o_new_second_alpha,
    output logic signed [31:0] o_new_bias
);

    localparam int NW      = 33 + FRAC_BITS;          // dividend width
    localparam int SUM_W   = NW + 2;
    localparam int ESC_W   = 35 + FRAC_BITS;
    localparam int GW      = 72;
    localparam int G_SPLIT = 24;
    localparam int PW      = 104;
    localparam int SW      = (FRAC_BITS > 18) ? 32 + FRAC_BITS : 50;
    localparam int RW      = 66;
    localparam int UW      = 67;
    localparam logic signed [UW+1:0] B_MAX = (UW+2)'(2147483647);
    localparam logic signed [UW+1:0] B_MIN = -B_MAX - (UW+2)'(1);

    // ---------------- configuration ----------------
    logic [30:0] r_box_c;
    logic [15:0] r_step_tol;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_c    <= BOX_C_RST;
            r_step_tol <= STEP_TOL_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_BOX_C:    r_box_c    <= pwdata[30:0];
                REG_STEP_TOL: r_step_tol <= pwdata[15:0];
                default:      r_box_c    <= r_box_c;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_BOX_C:    prdata = {1'b0, r_box_c};
            REG_STEP_TOL: prdata = {16'd0, r_step_tol};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // ---------------- pipe control ----------------
    logic w_adv;
    logic r_out_v;
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    logic r_s7_v, r_s8_v, r_s9_v, r_s10_v, r_s11_v;
    logic [NW-1:0] r_dl_v;

    assign w_adv   = !r_out_v || i_ready;
    assign o_ready = w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_s6_v  <= 1'b0;
            r_dl_v  <= '0;
            r_s7_v  <= 1'b0;
            r_s8_v  <= 1'b0;
            r_s9_v  <= 1'b0;
            r_s10_v <= 1'b0;
            r_s11_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_adv) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_s6_v  <= r_s5_v;
            r_dl_v  <= {r_dl_v[NW-2:0], r_s6_v};
            r_s7_v  <= r_dl_v[NW-1];
            r_s8_v  <= r_s7_v;
            r_s9_v  <= r_s8_v;
            r_s10_v <= r_s9_v;
            r_s11_v <= r_s10_v;
            r_out_v <= r_s11_v;
        end
    end

    // ---------------- stage 1: interval, eta, Newton numerator ----------------
    t_item n_s1_item, r_s1_item;
    logic signed [33:0] w_a1x, w_a2x, w_cx, w_lo, w_hi;
    logic signed [34:0] w_eta;
    logic signed [32:0] w_num;

    assign w_a1x = $signed({3'b000, i_first_alpha});
    assign w_a2x = $signed({3'b000, i_second_alpha});
    assign w_cx  = $signed({3'b000, r_box_c});

    always_comb begin
        if (i_first_label != i_second_label) begin
            w_lo = w_a2x - w_a1x;
            w_hi = w_cx + w_a2x - w_a1x;
        end else begin
            w_lo = w_a1x + w_a2x - w_cx;
            w_hi = w_a1x + w_a2x;
        end
        if (w_lo < 34'sd0) w_lo = '0;
        if (w_hi > w_cx)   w_hi = w_cx;

        w_eta = (35'(i_kernel_cross) <<< 1) - 35'(i_kernel_first_first)
              - 35'(i_kernel_second_second);
        w_num = i_second_label ? (33'(i_second_error) - 33'(i_first_error))
                               : (33'(i_first_error) - 33'(i_second_error));

        n_s1_item        = '0;
        n_s1_item.y1     = i_first_label;
        n_s1_item.y2     = i_second_label;
        n_s1_item.a1     = i_first_alpha;
        n_s1_item.a2     = i_second_alpha;
        n_s1_item.e1     = i_first_error;
        n_s1_item.e2     = i_second_error;
        n_s1_item.k11    = i_kernel_first_first;
        n_s1_item.kc     = i_kernel_cross;
        n_s1_item.k22    = i_kernel_second_second;
        n_s1_item.bias   = i_bias_in;
        n_s1_item.status = (w_lo >= w_hi) ? ST_EMPTY : ST_OK;
        n_s1_item.lo     = w_lo[30:0];
        n_s1_item.hi     = w_hi[30:0];
        n_s1_item.eta    = w_eta;
        n_s1_item.nmag   = w_num[32] ? $unsigned(-w_num) : $unsigned(w_num);
        n_s1_item.qneg   = !w_num[32] && (w_num != 33'sd0);
        n_s1_item.choice = CH_NEWTON;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_s1_item <= n_s1_item;
    end

    // ---------------- stage 2: eta * (L+H-2*a2) partials ----------------
    t_item r_s2_item;
    logic signed [33:0]      w_m;
    logic [ESC_W-1:0]        w_emag;
    logic signed [51:0]      n_s2_plo, n_s2_phi, r_s2_plo, r_s2_phi;
    logic signed [ESC_W-1:0] n_s2_esc, r_s2_esc;
    logic [30:0]             n_s2_d, r_s2_d;

    always_comb begin
        w_m = $signed({3'b000, r_s1_item.lo}) + $signed({3'b000, r_s1_item.hi})
            - $signed({2'b00, r_s1_item.a2, 1'b0});
        n_s2_plo = $signed({1'b0, r_s1_item.eta[16:0]}) * w_m;
        n_s2_phi = $signed(r_s1_item.eta[34:17]) * w_m;
        // 2*y2*(e1-e2)*S is -2*num*S
        w_emag   = ESC_W'(r_s1_item.nmag) << (FRAC_BITS + 1);
        n_s2_esc = r_s1_item.qneg ? -$signed(w_emag) : $signed(w_emag);
        n_s2_d   = r_s1_item.hi - r_s1_item.lo;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_item <= r_s1_item;
            r_s2_plo  <= n_s2_plo;
            r_s2_phi  <= n_s2_phi;
            r_s2_esc  <= n_s2_esc;
            r_s2_d    <= n_s2_d;
        end
    end

    // ---------------- stage 3: G ----------------
    t_item r_s3_item;
    logic signed [GW-1:0] n_s3_g, r_s3_g;
    logic [30:0]          r_s3_d;

    assign n_s3_g = (GW'(r_s2_phi) <<< 17) + GW'(r_s2_plo) + GW'(r_s2_esc);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_item <= r_s2_item;
            r_s3_g    <= n_s3_g;
            r_s3_d    <= r_s2_d;
        end
    end

    // ---------------- stage 4: G * (H-L) partials ----------------
    t_item r_s4_item;
    logic signed [56:0] n_s4_pl, n_s4_pm, r_s4_pl, r_s4_pm;
    logic signed [55:0] n_s4_ph, r_s4_ph;

    assign n_s4_pl = $signed({1'b0, r_s3_g[G_SPLIT-1:0]}) * $signed({1'b0, r_s3_d});
    assign n_s4_pm = $signed({1'b0, r_s3_g[2*G_SPLIT-1:G_SPLIT]}) * $signed({1'b0, r_s3_d});
    assign n_s4_ph = $signed(r_s3_g[GW-1:2*G_SPLIT]) * $signed({1'b0, r_s3_d});

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s4_item <= r_s3_item;
            r_s4_pl   <= n_s4_pl;
            r_s4_pm   <= n_s4_pm;
            r_s4_ph   <= n_s4_ph;
        end
    end

    // ---------------- stage 5: partial sum ----------------
    t_item r_s5_item;
    logic signed [PW-1:0] n_s5_p, r_s5_p;

    assign n_s5_p = (PW'(r_s4_ph) <<< (2*G_SPLIT)) + (PW'(r_s4_pm) <<< G_SPLIT)
                  + PW'(r_s4_pl);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s5_item <= r_s4_item;
            r_s5_p    <= n_s5_p;
        end
    end

    // ---------------- stage 6: endpoint choice ----------------
    t_item n_s6_item, r_s6_item;
    logic signed [PW-1:0] w_k;

    assign w_k = $signed(PW'(r_step_tol) << (2*FRAC_BITS + 1));

    always_comb begin
        n_s6_item = r_s5_item;
        priority if (r_s5_item.eta[34]) n_s6_item.choice = CH_NEWTON;
        else if (r_s5_p < -w_k)         n_s6_item.choice = CH_LO;
        else if (r_s5_p > w_k)          n_s6_item.choice = CH_HI;
        else                            n_s6_item.choice = CH_KEEP;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_s6_item <= n_s6_item;
    end

    // ---------------- divider: |num|*S / |eta| ----------------
    t_item          r_dl_item [NW];
    logic [34:0]    w_den;
    logic [NW-1:0]  w_quo;

    assign w_den = r_s6_item.eta[34] ? $unsigned(-r_s6_item.eta) : $unsigned(r_s6_item.eta);

    smo_pu_div #(
        .NUM_W (NW),
        .DEN_W (35)
    ) u_div (
        .i_clk (i_clk),
        .i_en  (w_adv),
        .i_num ({r_s6_item.nmag, {FRAC_BITS{1'b0}}}),
        .i_den (w_den),
        .o_quo (w_quo)
    );

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_dl_item[0] <= r_s6_item;
            for (int j = 1; j < NW; j++) r_dl_item[j] <= r_dl_item[j-1];
        end
    end

    // ---------------- stage 7: new second multiplier ----------------
    t_item n_s7_item, r_s7_item;
    logic signed [SUM_W-1:0] w_a2q, w_qq, w_sum, w_loq, w_hiq;

    always_comb begin
        n_s7_item = r_dl_item[NW-1];
        w_a2q = $signed(SUM_W'(r_dl_item[NW-1].a2));
        w_qq  = $signed(SUM_W'(w_quo));
        w_loq = $signed(SUM_W'(r_dl_item[NW-1].lo));
        w_hiq = $signed(SUM_W'(r_dl_item[NW-1].hi));
        w_sum = r_dl_item[NW-1].qneg ? w_a2q - w_qq : w_a2q + w_qq;
        unique case (r_dl_item[NW-1].choice)
            CH_NEWTON: begin
                priority if (w_sum < w_loq) n_s7_item.n2 = r_dl_item[NW-1].lo;
                else if (w_sum > w_hiq)     n_s7_item.n2 = r_dl_item[NW-1].hi;
                else                        n_s7_item.n2 = w_sum[30:0];
            end
            CH_LO:   n_s7_item.n2 = r_dl_item[NW-1].lo;
            CH_HI:   n_s7_item.n2 = r_dl_item[NW-1].hi;
            CH_KEEP: n_s7_item.n2 = r_dl_item[NW-1].a2;
            default: n_s7_item.n2 = r_dl_item[NW-1].a2;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_s7_item <= n_s7_item;
    end

    // ---------------- stage 8: step size terms, first multiplier clip ----------------
    t_item n_s8_item, r_s8_item;
    logic [30:0]        n_s8_dlt, r_s8_dlt;
    logic [48:0]        n_s8_prod, r_s8_prod;
    logic [32:0]        w_tsum;
    logic signed [33:0] w_n1, w_ex;
    logic signed [34:0] w_n2a;
    logic               w_same;

    always_comb begin
        n_s8_item = r_s7_item;
        n_s8_dlt  = (r_s7_item.n2 >= r_s7_item.a2) ? r_s7_item.n2 - r_s7_item.a2
                                                   : r_s7_item.a2 - r_s7_item.n2;
        w_tsum    = 33'(r_s7_item.n2) + 33'(r_s7_item.a2) + 33'(r_step_tol);
        n_s8_prod = 49'(r_step_tol) * 49'(w_tsum);

        w_same = (r_s7_item.y1 == r_s7_item.y2);
        if (w_same) begin
            w_n1 = $signed({3'b000, r_s7_item.a1}) - $signed({3'b000, r_s7_item.n2})
                 + $signed({3'b000, r_s7_item.a2});
        end else begin
            w_n1 = $signed({3'b000, r_s7_item.a1}) + $signed({3'b000, r_s7_item.n2})
                 - $signed({3'b000, r_s7_item.a2});
        end
        // excess past the box moves back onto the second multiplier
        priority if (w_n1 < 34'sd0) begin
            w_ex         = w_n1;
            n_s8_item.n1 = '0;
        end else if (w_n1 > w_cx) begin
            w_ex         = w_n1 - w_cx;
            n_s8_item.n1 = r_box_c;
        end else begin
            w_ex         = '0;
            n_s8_item.n1 = w_n1[30:0];
        end
        w_n2a = $signed({4'b0000, r_s7_item.n2});
        w_n2a = w_same ? w_n2a + 35'(w_ex) : w_n2a - 35'(w_ex);
        priority if (w_n2a < 35'sd0)          n_s8_item.n2 = '0;
        else if (w_n2a > 35'sd2147483647)     n_s8_item.n2 = '1;
        else                                  n_s8_item.n2 = w_n2a[30:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s8_item <= n_s8_item;
            r_s8_dlt  <= n_s8_dlt;
            r_s8_prod <= n_s8_prod;
        end
    end

    // ---------------- stage 9: small step test, t1 / t2 ----------------
    t_item n_s9_item, r_s9_item;
    logic signed [31:0] n_s9_t1, n_s9_t2, r_s9_t1, r_s9_t2;
    logic               w_small;

    always_comb begin
        n_s9_item = r_s8_item;
        w_small   = (SW'(r_s8_dlt) << FRAC_BITS) < SW'(r_s8_prod);
        if (r_s8_item.status == ST_OK && w_small) n_s9_item.status = ST_SMALL;
        n_s9_t1 = r_s8_item.y1 ? $signed({1'b0, r_s8_item.n1}) - $signed({1'b0, r_s8_item.a1})
                               : $signed({1'b0, r_s8_item.a1}) - $signed({1'b0, r_s8_item.n1});
        n_s9_t2 = r_s8_item.y2 ? $signed({1'b0, r_s8_item.n2}) - $signed({1'b0, r_s8_item.a2})
                               : $signed({1'b0, r_s8_item.a2}) - $signed({1'b0, r_s8_item.n2});
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s9_item <= n_s9_item;
            r_s9_t1   <= n_s9_t1;
            r_s9_t2   <= n_s9_t2;
        end
    end

    // ---------------- stage 10: kernel products ----------------
    t_item r_s10_item;
    logic signed [63:0] n_s10_m11, n_s10_mc1, n_s10_mc2, n_s10_m22;
    logic signed [63:0] r_s10_m11, r_s10_mc1, r_s10_mc2, r_s10_m22;

    assign n_s10_m11 = r_s9_t1 * r_s9_item.k11;
    assign n_s10_mc1 = r_s9_t2 * r_s9_item.kc;
    assign n_s10_mc2 = r_s9_t1 * r_s9_item.kc;
    assign n_s10_m22 = r_s9_t2 * r_s9_item.k22;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s10_item <= r_s9_item;
            r_s10_m11  <= n_s10_m11;
            r_s10_mc1  <= n_s10_mc1;
            r_s10_mc2  <= n_s10_mc2;
            r_s10_m22  <= n_s10_m22;
        end
    end

    // ---------------- stage 11: u1 / u2 with round to nearest ----------------
    t_item r_s11_item;
    logic signed [RW-1:0] w_sum1, w_sum2, w_rnd1, w_rnd2;
    logic signed [UW-1:0] n_s11_u1, n_s11_u2, r_s11_u1, r_s11_u2;

    always_comb begin
        w_sum1   = RW'(r_s10_m11) + RW'(r_s10_mc1);
        w_sum2   = RW'(r_s10_mc2) + RW'(r_s10_m22);
        w_rnd1   = (w_sum1 + (RW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        w_rnd2   = (w_sum2 + (RW'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        n_s11_u1 = UW'(r_s10_item.e1) + UW'(w_rnd1);
        n_s11_u2 = UW'(r_s10_item.e2) + UW'(w_rnd2);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s11_item <= r_s10_item;
            r_s11_u1   <= n_s11_u1;
            r_s11_u2   <= n_s11_u2;
        end
    end

    // ---------------- output register: bias select and saturate ----------------
    logic [1:0]           r_out_status;
    logic [30:0]          r_out_a1, r_out_a2;
    logic signed [31:0]   r_out_bias;
    logic signed [UW:0]   w_u, w_usum;
    logic signed [UW+1:0] w_b;
    logic signed [31:0]   w_bsat;

    always_comb begin
        w_usum = (UW+1)'(r_s11_u1) + (UW+1)'(r_s11_u2);
        priority if (r_s11_item.n1 != '0 && r_s11_item.n1 < r_box_c) w_u = (UW+1)'(r_s11_u1);
        else if (r_s11_item.n2 != '0 && r_s11_item.n2 < r_box_c)    w_u = (UW+1)'(r_s11_u2);
        else                                                         w_u = w_usum >>> 1;
        w_b = (UW+2)'(r_s11_item.bias) - (UW+2)'(w_u);
        priority if (w_b > B_MAX) w_bsat = 32'sh7FFF_FFFF;
        else if (w_b < B_MIN)     w_bsat = 32'sh8000_0000;
        else                      w_bsat = w_b[31:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= r_s11_item.status;
            if (r_s11_item.status == ST_OK) begin
                r_out_a1   <= r_s11_item.n1;
                r_out_a2   <= r_s11_item.n2;
                r_out_bias <= w_bsat;
            end else begin
                r_out_a1   <= r_s11_item.a1;
                r_out_a2   <= r_s11_item.a2;
                r_out_bias <= r_s11_item.bias;
            end
        end
    end

    assign o_valid            = r_out_v;
    assign o_status           = r_out_status;
    assign o_new_first_alpha  = r_out_a1;
    assign o_new_second_alpha = r_out_a2;
    assign o_new_bias         = r_out_bias;

    // ---------------- assertions ----------------
    a_n2_in_interval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s7_v && r_s7_item.status == ST_OK && r_s7_item.choice != CH_KEEP)
        |-> (r_s7_item.n2 >= r_s7_item.lo && r_s7_item.n2 <= r_s7_item.hi))
        else $error("second multiplier left its interval");

    a_empty_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_s8_v && r_s8_item.status == ST_EMPTY)
        |=> (r_s9_v && r_s9_item.status == ST_EMPTY))
        else $error("empty interval status lost");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_adv && r_s7_v) |=> (r_s7_v && $stable(r_s7_item.n2)))
        else $error("pipe moved during a stall");

endmodule
`default_nettype wire

// File: sim/tb_svm_smo_pair_update.sv
`default_nettype none
// ---------------------------------------------------------------------------
// tb_svm_smo_pair_update
// Self-checking bench for the SMO pair update. Sample pairs are streamed in
// under random gaps and back-pressure. A scoreboard predicts the bounds, the
// Newton or endpoint step, the clip and the bias of every word. It checks
// each output word in order, under several box and tolerance settings.
// ---------------------------------------------------------------------------
module tb_svm_smo_pair_update;
    import smo_pu_pkg::*;

    typedef struct {
        bit               y1;
        bit               y2;
        bit [30:0]        a1;
        bit [30:0]        a2;
        bit signed [31:0] e1;
        bit signed [31:0] e2;
        bit signed [31:0] k11;
        bit signed [31:0] kc;
        bit signed [31:0] k22;
        bit signed [31:0] bias;
    } pair_t;

    typedef struct {
        bit [1:0]         status;
        bit [30:0]        n1;
        bit [30:0]        n2;
        bit signed [31:0] bias;
    } update_t;

    typedef logic signed [127:0] wide_t;

    class pair_scoreboard;
        bit [30:0] box_c = BOX_C_RST;
        bit [15:0] step_tol = STEP_TOL_RST;
        update_t   expected_q[$];
        int        errors;
        int        n_checked;
        int        n_status[3];

        function update_t predict_update(pair_t p);
            wide_t S, y1, y2, a1, a2, e1, e2, k11, kc, k22, b, c, eps, s;
            wide_t lo, hi, eta, num, mag, qm, n1, n2, g, pr, kk, dlt;
            wide_t t1, t2, u1, u2, u, nb;
            update_t r;
            S = 65536;
            y1 = p.y1 ? 1 : -1;
            y2 = p.y2 ? 1 : -1;
            a1 = p.a1; a2 = p.a2;
            e1 = p.e1; e2 = p.e2;
            k11 = p.k11; kc = p.kc; k22 = p.k22; b = p.bias;
            c = box_c; eps = step_tol;
            s = y1 * y2;
            r.status = ST_OK; r.n1 = p.a1; r.n2 = p.a2; r.bias = p.bias;
            if (s < 0) begin
                lo = a2 - a1; if (lo < 0) lo = 0;
                hi = c + a2 - a1; if (hi > c) hi = c;
            end else begin
                lo = a1 + a2 - c; if (lo < 0) lo = 0;
                hi = a1 + a2; if (hi > c) hi = c;
            end
            if (lo >= hi) begin
                r.status = ST_EMPTY;
                return r;
            end
            eta = 2 * kc - k11 - k22;
            if (eta < 0) begin
                num = y2 * (e2 - e1);
                mag = (num < 0) ? -num : num;
                qm = (mag * S) / (-eta);
                n2 = a2 + ((num > 0) ? -qm : qm);
                if (n2 < lo) n2 = lo;
                else if (n2 > hi) n2 = hi;
            end else begin
                // exact endpoint objective comparison, no division
                g = eta * (lo + hi - 2 * a2) + 2 * y2 * (e1 - e2) * S;
                pr = g * (hi - lo);
                kk = 2 * eps * S * S;
                if (pr < -kk) n2 = lo;
                else if (pr > kk) n2 = hi;
                else n2 = a2;
            end
            dlt = n2 - a2;
            if (dlt < 0) dlt = -dlt;
            if (dlt * S < eps * (n2 + a2 + eps)) begin
                r.status = ST_SMALL;
                return r;
            end
            n1 = a1 - s * (n2 - a2);
            if (n1 < 0) begin
                n2 = n2 + s * n1; n1 = 0;
            end else if (n1 > c) begin
                n2 = n2 + s * (n1 - c); n1 = c;
            end
            if (n2 < 0) n2 = 0;
            if (n2 > 2147483647) n2 = 2147483647;
            t1 = y1 * (n1 - a1);
            t2 = y2 * (n2 - a2);
            u1 = e1 + ((t1 * k11 + t2 * kc + 32768) >>> 16);
            u2 = e2 + ((t1 * kc + t2 * k22 + 32768) >>> 16);
            if (n1 > 0 && n1 < c) u = u1;
            else if (n2 > 0 && n2 < c) u = u2;
            else u = (u1 + u2) >>> 1;
            nb = b - u;
            if (nb > 2147483647) nb = 2147483647;
            if (nb < -64'sd2147483648) nb = -64'sd2147483648;
            r.n1 = n1[30:0];
            r.n2 = n2[30:0];
            r.bias = nb[31:0];
            return r;
        endfunction

        function void note_pair(pair_t p);
            expected_q.push_back(predict_update(p));
        endfunction

        function void check_update(update_t act);
            update_t ex;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected word status=%0d n1=%h n2=%h bias=%h", $time,
                         act.status, act.n1, act.n2, act.bias);
                errors++;
                return;
            end
            ex = expected_q.pop_front();
            n_checked++;
            if (ex.status <= ST_SMALL) n_status[ex.status]++;
            if (act.status !== ex.status) begin
                $display("%0t: status exp %0d got %0d", $time, ex.status, act.status);
                errors++;
            end
            if (act.n1 !== ex.n1) begin
                $display("%0t: new_first_alpha exp %h got %h", $time, ex.n1, act.n1);
                errors++;
            end
            if (act.n2 !== ex.n2) begin
                $display("%0t: new_second_alpha exp %h got %h", $time, ex.n2, act.n2);
                errors++;
            end
            if (act.bias !== ex.bias) begin
                $display("%0t: new_bias exp %h got %h", $time, ex.bias, act.bias);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_first_label = 1'b0;
    logic               i_second_label = 1'b0;
    logic [30:0]        i_first_alpha = '0;
    logic [30:0]        i_second_alpha = '0;
    logic signed [31:0] i_first_error = '0;
    logic signed [31:0] i_second_error = '0;
    logic signed [31:0] i_kernel_first_first = '0;
    logic signed [31:0] i_kernel_cross = '0;
    logic signed [31:0] i_kernel_second_second = '0;
    logic signed [31:0] i_bias_in = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [1:0]         o_status;
    logic [30:0]        o_new_first_alpha;
    logic [30:0]        o_new_second_alpha;
    logic signed [31:0] o_new_bias;

    svm_smo_pair_update dut (.*);

    pair_scoreboard sb = new();
    int  snd_idle = 33;
    int  rcv_idle = 71;
    bit  hold_request = 1'b0;
    int  cycles = 0;
    localparam int CYCLE_LIMIT = 400000;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge i_clk) begin : rx_drive
        static int hold_left = 0;
        static bit hold_done = 1'b0;
        if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) begin
            pair_t p;
            p.y1 = i_first_label; p.y2 = i_second_label;
            p.a1 = i_first_alpha; p.a2 = i_second_alpha;
            p.e1 = i_first_error; p.e2 = i_second_error;
            p.k11 = i_kernel_first_first; p.kc = i_kernel_cross;
            p.k22 = i_kernel_second_second; p.bias = i_bias_in;
            sb.note_pair(p);
        end
        if (i_rst_n && o_valid && i_ready) begin
            update_t r;
            r.status = o_status; r.n1 = o_new_first_alpha;
            r.n2 = o_new_second_alpha; r.bias = o_new_bias;
            sb.check_update(r);
        end
    end

    task automatic reg_write(input logic idx, input logic [31:0] value);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == REG_BOX_C) sb.box_c = value[30:0];
        else sb.step_tol = value[15:0];
    endtask

    task automatic send_pair(input pair_t p);
        if ($urandom_range(99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < snd_idle) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_first_label <= p.y1; i_second_label <= p.y2;
        i_first_alpha <= p.a1; i_second_alpha <= p.a2;
        i_first_error <= p.e1; i_second_error <= p.e2;
        i_kernel_first_first <= p.k11; i_kernel_cross <= p.kc;
        i_kernel_second_second <= p.k22; i_bias_in <= p.bias;
        do @(posedge i_clk); while (!o_ready);
    endtask

    function automatic bit [30:0] pick_alpha(bit [30:0] c);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 31'd0;
        if (r < 20) return c;
        if (r < 85) return 31'($urandom_range(c));
        return 31'($urandom);
    endfunction

    function automatic bit signed [31:0] small_signed(int unsigned span);
        return 32'(int'($urandom_range(2 * span)) - int'(span));
    endfunction

    function automatic pair_t random_pair(bit [30:0] c);
        pair_t p;
        int unsigned r;
        p.y1 = 1'($urandom); p.y2 = 1'($urandom);
        r = $urandom_range(99);
        if (r < 10) begin
            // raw noise across every bit
            p.a1 = 31'($urandom); p.a2 = 31'($urandom);
            p.e1 = $urandom; p.e2 = $urandom;
            p.k11 = $urandom; p.kc = $urandom; p.k22 = $urandom;
            p.bias = $urandom;
        end else begin
            p.a1 = pick_alpha(c); p.a2 = pick_alpha(c);
            p.e1 = small_signed(1 << ($urandom_range(12, 22)));
            p.e2 = small_signed(1 << ($urandom_range(12, 22)));
            p.k11 = 32'($urandom_range(1 << 18));
            p.k22 = 32'($urandom_range(1 << 18));
            if (r < 30) p.kc = (p.k11 >>> 1) + (p.k22 >>> 1) + small_signed(256);
            else p.kc = small_signed(1 << 16);
            p.bias = small_signed(1 << 20);
        end
        return p;
    endfunction

    task automatic drain_pipe();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (70) @(posedge i_clk);
    endtask

    task automatic run_directed();
        pair_t p, z;
        z = '{default: 0};
        p = z; send_pair(p);                          // empty interval
        p = z; p.y1 = 1; p.a1 = 31'h7FFFFFFF; p.a2 = 31'h7FFFFFFF;
        p.e1 = 32'h7FFFFFFF; p.e2 = 32'h80000000; send_pair(p);
        p.y2 = 1; p.k11 = 32'h80000000; p.k22 = 32'h80000000;
        p.kc = 32'h7FFFFFFF; p.bias = 32'h80000000; send_pair(p);
        for (int i = 0; i < 4; i++) begin
            p = z; p.y1 = i[0]; p.y2 = i[1];
            p.a1 = 31'd20000; p.a2 = 31'd30000;
            p.e1 = 32'sd65536; p.e2 = -32'sd65536;
            p.k11 = 32'sd65536; p.k22 = 32'sd65536; p.kc = 32'sd16384;
            p.bias = 32'sd1000;
            send_pair(p);                             // Newton step
            p.kc = 32'sd65536; send_pair(p);          // eta zero
            p.kc = 32'sd131072; send_pair(p);         // eta positive
            p.e2 = p.e1; send_pair(p);                // equal errors, eta positive
        end
        p = z; p.y1 = 1; p.a1 = 31'd200000; p.a2 = 31'd300000;   // alphas outside the reset box
        p.e1 = 32'sd5000; p.e2 = -32'sd7000; p.k11 = 32'sd70000;
        p.k22 = 32'sd80000; p.kc = 32'sd100; send_pair(p);
        p.e2 = 32'sd5001; send_pair(p);               // errors one apart
        p = z; p.y1 = 1; p.y2 = 1; p.a1 = 31'd65536; p.a2 = 31'd65536;
        p.e1 = 32'sd9000; p.e2 = -32'sd9000; p.k11 = 32'sd60000; send_pair(p);
    endtask

    initial begin
        int n_items;
        n_items = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: begin
                    reg_write(REG_BOX_C, 32'h7FFFFFFF);
                    reg_write(REG_STEP_TOL, 32'd0);
                end
                2: begin
                    snd_idle = 71; rcv_idle = 33;
                    reg_write(REG_BOX_C, 32'd1);
                    reg_write(REG_STEP_TOL, 32'd65535);
                end
                3: begin
                    reg_write(REG_BOX_C, 32'h0003_0000);
                    reg_write(REG_STEP_TOL, 32'd1);
                end
                4: begin
                    snd_idle = 0; rcv_idle = 0;
                    reg_write(REG_BOX_C, 32'h0001_8000);
                    reg_write(REG_STEP_TOL, 32'd66);
                    hold_request = 1'b1;
                end
                default: ;
            endcase
            if (ph == 0 || ph == 1) run_directed();
            for (int i = 0; i < 300; i++) begin
                send_pair(random_pair(sb.box_c));
                n_items++;
            end
            drain_pipe();
        end
        $display("Checked %0d words over 5 settings (box 1 .. 2^31-1, tolerance 0 .. 65535).",
                 sb.n_checked);
        $display("Outcomes: %0d updated, %0d empty interval, %0d step too small.",
                 sb.n_status[0], sb.n_status[1], sb.n_status[2]);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
